>>> rtl/core/light_sensor_autogain_lux_defines.svh
// Assertion macros shared by the light sensor auto-gain checker.
// Depends on nothing; included by the checker file only.
`ifndef LIGHT_SENSOR_AUTOGAIN_LUX_DEFINES_SVH
`define LIGHT_SENSOR_AUTOGAIN_LUX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lsal_pkg.sv
// Package for the light sensor auto-gain and lux block: codes, item types
// and the per-gain constant tables of the lux scaling. No dependencies.
package lsal_pkg;

    typedef enum logic [1:0] {
        GAIN_1X    = 2'd0,
        GAIN_25X   = 2'd1,
        GAIN_428X  = 2'd2,
        GAIN_9876X = 2'd3
    } gain_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_BUSY = 2'd1,
        STATUS_OFF  = 2'd2
    } status_t;

    typedef enum logic {
        MODE_READING  = 1'b0,
        MODE_POWER_ON = 1'b1
    } mode_t;

    localparam logic REG_HIGH_THRESHOLD = 1'b0;
    localparam logic REG_LOW_THRESHOLD  = 1'b1;

    localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd60000;
    localparam logic [15:0] LOW_THRESHOLD_RESET  = 16'd500;

    localparam int COUNT_W = 16;
    localparam int MAG_W   = 17;
    localparam int PROD_W  = 32;
    localparam int QUOT_W  = 28;
    localparam int LUX_W   = 29;

    typedef struct packed {
        status_t status;
        gain_t   gain_next;
        logic    gain_write;
    } item_meta_t;

    typedef struct packed {
        logic                 compute;
        gain_t                gain;
        logic [COUNT_W-1:0]   full_count;
        logic [COUNT_W-1:0]   infrared_count;
        item_meta_t           meta;
    } lux_req_t;

    typedef struct packed {
        logic signed [LUX_W-1:0] lux_value;
        item_meta_t              meta;
    } lux_result_t;

    // Lux = diff * 104448 / (100 * gain), reduced to diff * num / den.
    function automatic logic [14:0] scale_num(input gain_t g);
        logic [14:0] n;
        unique case (g)
            GAIN_1X:    n = 15'd26112;
            GAIN_25X:   n = 15'd26112;
            GAIN_428X:  n = 15'd6528;
            GAIN_9876X: n = 15'd2176;
            default:    n = 15'd26112;
        endcase
        return n;
    endfunction

    function automatic logic [14:0] scale_den(input gain_t g);
        logic [14:0] d;
        unique case (g)
            GAIN_1X:    d = 15'd25;
            GAIN_25X:   d = 15'd625;
            GAIN_428X:  d = 15'd2675;
            GAIN_9876X: d = 15'd20575;
            default:    d = 15'd25;
        endcase
        return d;
    endfunction

    // Floor of 2^32 / den; the quotient estimate is then low by at most one.
    function automatic logic [QUOT_W-1:0] scale_recip(input gain_t g);
        logic [QUOT_W-1:0] r;
        unique case (g)
            GAIN_1X:    r = 28'd171798691;
            GAIN_25X:   r = 28'd6871947;
            GAIN_428X:  r = 28'd1605595;
            GAIN_9876X: r = 28'd208746;
            default:    r = 28'd171798691;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/lsal_gain_ctrl.sv
// Gain state and per-item decisions: status, next gain and write request.
// Depends on lsal_pkg.
module lsal_gain_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              mode,
    input  logic [15:0]       full_count,
    input  logic [15:0]       infrared_count,
    input  logic              powered,
    input  logic [15:0]       high_threshold,
    input  logic [15:0]       low_threshold,
    output lsal_pkg::lux_req_t req
);
    import lsal_pkg::*;

    gain_t gain_step_reg;
    gain_t gain_step_next;
    logic  above;
    logic  below;

    assign above = full_count > high_threshold;
    assign below = full_count < low_threshold;

    always_comb
    begin
        req.compute             = 1'b0;
        req.gain                = gain_step_reg;
        req.full_count          = full_count;
        req.infrared_count      = infrared_count;
        req.meta.status         = STATUS_OK;
        req.meta.gain_next      = gain_step_reg;
        req.meta.gain_write     = 1'b0;
        priority if (mode_t'(mode) == MODE_POWER_ON)
        begin
            req.meta.gain_next  = GAIN_25X;
            req.meta.gain_write = 1'b1;
        end
        else if (!powered)
        begin
            req.meta.status     = STATUS_OFF;
        end
        else
        begin
            req.compute = 1'b1;
            priority if (above)
            begin
                if (gain_step_reg != GAIN_1X)
                begin
                    req.meta.gain_next = gain_t'(gain_step_reg - 2'd1);
                end
            end
            else if (below)
            begin
                if (gain_step_reg != GAIN_9876X)
                begin
                    req.meta.gain_next = gain_t'(gain_step_reg + 2'd1);
                end
            end
            else
            begin
                req.meta.gain_next = gain_step_reg;
            end
            req.meta.gain_write = req.meta.gain_next != gain_step_reg;
            if (above || below)
            begin
                req.meta.status = STATUS_BUSY;
            end
        end
    end

    assign gain_step_next = accept ? req.meta.gain_next : gain_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_step_reg <= GAIN_25X;
        end
        else
        begin
            gain_step_reg <= gain_step_next;
        end
    end

endmodule

>>> rtl/core/lsal_lux_pipe.sv
// Five-register lux pipeline: magnitude, scale multiply, reciprocal multiply,
// back-multiply and remainder correction. Depends on lsal_pkg.
module lsal_lux_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lsal_pkg::lux_req_t    in_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lsal_pkg::lux_result_t out_result
);
    import lsal_pkg::*;

    localparam int STAGES = 5;

    typedef struct packed {
        logic             neg;
        gain_t            gain;
        logic [MAG_W-1:0] mag;
        item_meta_t       meta;
    } st1_t;

    typedef struct packed {
        logic              neg;
        gain_t             gain;
        logic [PROD_W-1:0] prod;
        item_meta_t        meta;
    } st2_t;

    typedef struct packed {
        logic              neg;
        gain_t             gain;
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        item_meta_t        meta;
    } st3_t;

    typedef struct packed {
        logic              neg;
        gain_t             gain;
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        logic [PROD_W-1:0] back;
        item_meta_t        meta;
    } st4_t;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;

    st1_t        s1_reg, s1_next;
    st2_t        s2_reg, s2_next;
    st3_t        s3_reg, s3_next;
    st4_t        s4_reg, s4_next;
    lux_result_t s5_reg, s5_next;

    logic signed [MAG_W:0]         diff;
    logic [PROD_W+QUOT_W-1:0]      recip_prod;
    logic [PROD_W-1:0]             remainder;
    logic [QUOT_W-1:0]             quot_fixed;

    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        diff = $signed({2'b00, in_req.full_count}) - $signed({1'b0, in_req.infrared_count, 1'b0});
        s1_next.gain = in_req.gain;
        s1_next.meta = in_req.meta;
        s1_next.neg  = 1'b0;
        s1_next.mag  = '0;
        if (in_req.compute)
        begin
            s1_next.neg = diff[MAG_W];
            s1_next.mag = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
        end
    end

    always_comb
    begin
        s2_next.neg  = s1_reg.neg;
        s2_next.gain = s1_reg.gain;
        s2_next.meta = s1_reg.meta;
        s2_next.prod = {{(PROD_W-MAG_W){1'b0}}, s1_reg.mag}
                       * {{(PROD_W-15){1'b0}}, scale_num(s1_reg.gain)};
    end

    always_comb
    begin
        recip_prod   = {{QUOT_W{1'b0}}, s2_reg.prod}
                       * {{PROD_W{1'b0}}, scale_recip(s2_reg.gain)};
        s3_next.neg  = s2_reg.neg;
        s3_next.gain = s2_reg.gain;
        s3_next.meta = s2_reg.meta;
        s3_next.prod = s2_reg.prod;
        s3_next.quot = recip_prod[PROD_W+QUOT_W-1:PROD_W];
    end

    always_comb
    begin
        s4_next.neg  = s3_reg.neg;
        s4_next.gain = s3_reg.gain;
        s4_next.meta = s3_reg.meta;
        s4_next.prod = s3_reg.prod;
        s4_next.quot = s3_reg.quot;
        s4_next.back = {{(PROD_W-QUOT_W){1'b0}}, s3_reg.quot}
                       * {{(PROD_W-15){1'b0}}, scale_den(s3_reg.gain)};
    end

    always_comb
    begin
        remainder  = s4_reg.prod - s4_reg.back;
        quot_fixed = s4_reg.quot;
        if (remainder >= {{(PROD_W-15){1'b0}}, scale_den(s4_reg.gain)})
        begin
            quot_fixed = s4_reg.quot + QUOT_W'(1);
        end
        s5_next.meta      = s4_reg.meta;
        s5_next.lux_value = s4_reg.neg ? -$signed({1'b0, quot_fixed})
                                       : $signed({1'b0, quot_fixed});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
        if (en[3])
        begin
            s4_reg <= s4_next;
        end
        if (en[4])
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid  = valid_reg[STAGES-1];
    assign out_result = s5_reg;

endmodule

>>> rtl/core/light_sensor_autogain_lux.sv
// Light sensor auto-gain control with lux conversion, top level.
// A result passes through five register stages after its input transfer.
// Throughput: one item per cycle unless stalled; gain step is set at the input transfer.
// Stalls hold the whole pipeline back only once every stage is full.
// Reset clears all valid state, sets the gain to 25x and the thresholds to 60000 and 500.
// Depends on lsal_pkg, lsal_gain_ctrl and lsal_lux_pipe.
module light_sensor_autogain_lux (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] full_count, [31:16] infrared_count, [32] powered, [39:33] zero
    input  logic [39:0] s_axis_tdata,
    // [0] mode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [28:0] lux_value, [30:29] status, [32:31] gain_next, [33] gain_write, [39:34] zero
    output logic [39:0] m_axis_tdata
);
    import lsal_pkg::*;

    logic [15:0] high_threshold_reg;
    logic [15:0] high_threshold_next;
    logic [15:0] low_threshold_reg;
    logic [15:0] low_threshold_next;
    logic        in_accept;
    lux_req_t    req;
    lux_result_t result;

    always_comb
    begin
        high_threshold_next = high_threshold_reg;
        low_threshold_next  = low_threshold_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HIGH_THRESHOLD: high_threshold_next = cfg_wdata;
                REG_LOW_THRESHOLD:  low_threshold_next  = cfg_wdata;
                default:            high_threshold_next = high_threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_threshold_reg <= HIGH_THRESHOLD_RESET;
            low_threshold_reg  <= LOW_THRESHOLD_RESET;
        end
        else
        begin
            high_threshold_reg <= high_threshold_next;
            low_threshold_reg  <= low_threshold_next;
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    lsal_gain_ctrl u_gain_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .mode           (s_axis_tuser),
        .full_count     (s_axis_tdata[15:0]),
        .infrared_count (s_axis_tdata[31:16]),
        .powered        (s_axis_tdata[32]),
        .high_threshold (high_threshold_reg),
        .low_threshold  (low_threshold_reg),
        .req            (req)
    );

    lsal_lux_pipe u_lux_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (req),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {6'b000000, result.meta.gain_write, result.meta.gain_next,
                           result.meta.status, result.lux_value};

endmodule

>>> rtl/core/lsal_checker.sv
// Port-level checker for the light sensor auto-gain block, bound to the top level.
// Depends on lsal_pkg and light_sensor_autogain_lux_defines.svh.
`include "light_sensor_autogain_lux_defines.svh"

module lsal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    import lsal_pkg::*;

    logic is_off;

    assign is_off = m_axis_tdata[30:29] == STATUS_OFF;

    `LSAL_ASSERT_NEXT(a_out_valid_held, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid, "result transfer withdrawn while stalled")
    `LSAL_ASSERT_NEXT(a_out_data_held, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata), "result payload changed while stalled")
    `LSAL_ASSERT_NOW(a_full_before_stall, clk, rst_n, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled although the output is free")
    `LSAL_ASSERT_NOW(a_off_is_quiet, clk, rst_n, m_axis_tvalid && is_off,
        m_axis_tdata[28:0] == 29'd0 && !m_axis_tdata[33], "sensor-off result not quiet")

endmodule

bind light_sensor_autogain_lux lsal_checker u_lsal_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
